// ===== rtl/core/ipef_pkg.sv =====
// Shared types and constants for the IP prefix event filter.
// Holds the stream beat layouts, the queue item, the config bundle and the codes.
// No dependencies.
`timescale 1ns / 1ps

package ipef_pkg;

    localparam int V4_ENTRIES  = 16;
    localparam int V6_ENTRIES  = 16;
    localparam int V4_IDX_W    = (V4_ENTRIES > 1) ? $clog2(V4_ENTRIES) : 1;
    localparam int V6_IDX_W    = (V6_ENTRIES > 1) ? $clog2(V6_ENTRIES) : 1;
    localparam int QUEUE_DEPTH = 2;

    localparam int IN_TDATA_W  = 376;
    localparam int OUT_TDATA_W = 328;
    localparam int CNT_REG_W   = 5;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    // input opcodes
    localparam logic [1:0] OP_PACKET = 2'd0;
    localparam logic [1:0] OP_WR_V4  = 2'd1;
    localparam logic [1:0] OP_WR_V6  = 2'd2;

    localparam logic [3:0] IP_VER4 = 4'd4;
    localparam logic [3:0] IP_VER6 = 4'd6;

    localparam logic [7:0] MAX_PREFIX = 8'd128;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_IPV4_COUNT = 2'd0;
    localparam logic [1:0] REG_IPV6_COUNT = 2'd1;
    localparam logic [1:0] REG_DROP_MODE  = 2'd2;

    typedef enum logic [1:0] {
        KIND_WR_V4,
        KIND_WR_V6,
        KIND_PKT_V4,
        KIND_PKT_V6
    } item_kind_t;

    // input tdata, last member in the lowest bits
    typedef struct packed {
        logic [6:0]  pad;
        logic [7:0]  entry_prefix;
        logic [31:0] entry_mask;
        logic [3:0]  entry_index;
        logic [63:0] dst_low;
        logic [63:0] dst_high;
        logic [63:0] src_low;
        logic [63:0] src_high;
        logic [3:0]  ip_version;
        logic [31:0] byte_count;
        logic [31:0] owner_id;
        logic        direction;
    } in_beat_t;

    // output tdata, last member in the lowest bits
    typedef struct packed {
        logic [6:0]  pad;
        logic [63:0] dst_low;
        logic [63:0] dst_high;
        logic [63:0] src_low;
        logic [63:0] src_high;
        logic [31:0] byte_count;
        logic [31:0] owner_id;
        logic        direction;
    } out_beat_t;

    typedef struct packed {
        item_kind_t  kind;
        logic        direction;
        logic [31:0] owner_id;
        logic [31:0] byte_count;
        logic [63:0] src_high;
        logic [63:0] src_low;
        logic [63:0] dst_high;
        logic [63:0] dst_low;
        logic [3:0]  entry_index;
        logic [31:0] entry_mask;
        logic [7:0]  entry_prefix;
    } work_item_t;

    typedef struct packed {
        logic [CNT_REG_W-1:0] ipv4_entry_count;
        logic [CNT_REG_W-1:0] ipv6_entry_count;
        logic                 drop_when_either;
    } filter_cfg_t;

endpackage

// ===== rtl/core/ipef_front.sv =====
// Front end: unpacks an input beat, classifies it and forms a queue item.
// Depends on ipef_pkg.
`timescale 1ns / 1ps

module ipef_front
    import ipef_pkg::*;
(
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,
    input  logic [1:0]            s_tuser,
    output logic                  push_valid,
    input  logic                  push_ready,
    output work_item_t            push_item
);

    in_beat_t beat;
    logic     keep;

    assign beat     = in_beat_t'(s_tdata);
    assign s_tready = push_ready;

    always_comb
    begin
        keep                   = 1'b1;
        push_item.kind         = KIND_PKT_V4;
        push_item.direction    = beat.direction;
        push_item.owner_id     = beat.owner_id;
        push_item.byte_count   = beat.byte_count;
        push_item.src_high     = beat.src_high;
        push_item.src_low      = beat.src_low;
        push_item.dst_high     = beat.dst_high;
        push_item.dst_low      = beat.dst_low;
        push_item.entry_index  = beat.entry_index;
        push_item.entry_mask   = beat.entry_mask;
        push_item.entry_prefix = (beat.entry_prefix > MAX_PREFIX) ? MAX_PREFIX
                                                                  : beat.entry_prefix;
        case (s_tuser)
            OP_WR_V4: push_item.kind = KIND_WR_V4;
            OP_WR_V6: push_item.kind = KIND_WR_V6;
            OP_PACKET:
            begin
                if (beat.ip_version == IP_VER4)
                begin
                    // IPv4: only the low 32 bits of each low word count
                    push_item.kind     = KIND_PKT_V4;
                    push_item.src_high = '0;
                    push_item.dst_high = '0;
                    push_item.src_low  = {32'd0, beat.src_low[31:0]};
                    push_item.dst_low  = {32'd0, beat.dst_low[31:0]};
                end
                else if (beat.ip_version == IP_VER6)
                begin
                    push_item.kind = KIND_PKT_V6;
                end
                else
                begin
                    keep = 1'b0;
                end
            end
            default: keep = 1'b0;
        endcase
    end

    // items that give no result and change no state are consumed here
    assign push_valid = s_tvalid && keep;

endmodule

// ===== rtl/core/ipef_queue.sv =====
// Short FIFO between front and back end, carrying work items.
// Depends on ipef_pkg.
`timescale 1ns / 1ps

module ipef_queue
    import ipef_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_ready,
    input  work_item_t push_item,
    output logic       pop_valid,
    input  logic       pop_ready,
    output work_item_t pop_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    work_item_t       slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not grow on push");

    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue count did not shrink on pop");

endmodule

// ===== rtl/core/ipef_back.sv =====
// Back end: holds the prefix tables, performs table writes and matches packets,
// and keeps the output register. Depends on ipef_pkg.
`timescale 1ns / 1ps

module ipef_back
    import ipef_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  filter_cfg_t            cfg,
    input  logic                   pop_valid,
    output logic                   pop_ready,
    input  work_item_t             pop_item,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tuser
);

    // mask bits for the 64-bit word of a prefix that starts at bit base
    function automatic logic [63:0] prefix_word(input logic [7:0] p, input logic [7:0] base);
        logic [8:0]  span;
        logic [63:0] word;
        span = {1'b0, p} - {1'b0, base};
        if (p <= base)
            word = '0;
        else if (span >= 9'd64)
            word = '1;
        else
            word = ~64'd0 << (7'd64 - span[6:0]);
        return word;
    endfunction

    logic [63:0] v4_table_reg  [V4_ENTRIES];
    logic [63:0] v6_net_hi_reg [V6_ENTRIES];
    logic [63:0] v6_net_lo_reg [V6_ENTRIES];
    logic [7:0]  v6_prefix_reg [V6_ENTRIES];

    logic              out_valid_reg;
    out_beat_t         out_data_reg;
    logic              out_v6_reg;

    logic              pop;
    logic [V4_ENTRIES-1:0] v4_src_hit, v4_dst_hit;
    logic [V6_ENTRIES-1:0] v6_src_hit, v6_dst_hit;
    logic              src_hit, dst_hit, drop, load;
    logic [V4_IDX_W-1:0] v4_wr_idx;
    logic [V6_IDX_W-1:0] v6_wr_idx;
    logic              v4_wr, v6_wr;

    assign pop_ready = !out_valid_reg || m_tready;
    assign pop       = pop_valid && pop_ready;

    assign v4_wr_idx = V4_IDX_W'(pop_item.entry_index);
    assign v6_wr_idx = V6_IDX_W'(pop_item.entry_index);
    assign v4_wr = pop && (pop_item.kind == KIND_WR_V4)
                   && (32'(pop_item.entry_index) < V4_ENTRIES);
    assign v6_wr = pop && (pop_item.kind == KIND_WR_V6)
                   && (32'(pop_item.entry_index) < V6_ENTRIES);

    // one compare lane per table entry; lanes at or above the count are off
    always_comb
    begin
        for (int i = 0; i < V4_ENTRIES; i++)
        begin
            v4_src_hit[i] = (32'(cfg.ipv4_entry_count) > i) &&
                ((pop_item.src_low[31:0] & v4_table_reg[i][63:32]) == v4_table_reg[i][31:0]);
            v4_dst_hit[i] = (32'(cfg.ipv4_entry_count) > i) &&
                ((pop_item.dst_low[31:0] & v4_table_reg[i][63:32]) == v4_table_reg[i][31:0]);
        end
        for (int i = 0; i < V6_ENTRIES; i++)
        begin
            v6_src_hit[i] = (32'(cfg.ipv6_entry_count) > i) &&
                (((pop_item.src_high ^ v6_net_hi_reg[i]) & prefix_word(v6_prefix_reg[i], 8'd0))
                 == '0) &&
                (((pop_item.src_low ^ v6_net_lo_reg[i]) & prefix_word(v6_prefix_reg[i], 8'd64))
                 == '0);
            v6_dst_hit[i] = (32'(cfg.ipv6_entry_count) > i) &&
                (((pop_item.dst_high ^ v6_net_hi_reg[i]) & prefix_word(v6_prefix_reg[i], 8'd0))
                 == '0) &&
                (((pop_item.dst_low ^ v6_net_lo_reg[i]) & prefix_word(v6_prefix_reg[i], 8'd64))
                 == '0);
        end
    end

    always_comb
    begin
        case (pop_item.kind)
            KIND_PKT_V4:
            begin
                src_hit = |v4_src_hit;
                dst_hit = |v4_dst_hit;
            end
            KIND_PKT_V6:
            begin
                src_hit = |v6_src_hit;
                dst_hit = |v6_dst_hit;
            end
            default:
            begin
                src_hit = 1'b0;
                dst_hit = 1'b0;
            end
        endcase
        drop = cfg.drop_when_either ? (src_hit || dst_hit) : (src_hit && dst_hit);
        load = pop && !drop &&
               ((pop_item.kind == KIND_PKT_V4) || (pop_item.kind == KIND_PKT_V6));
    end

    always_ff @(posedge clk)
    begin
        if (v4_wr)
            v4_table_reg[v4_wr_idx] <= {pop_item.entry_mask, pop_item.src_low[31:0]};
        if (v6_wr)
        begin
            v6_net_hi_reg[v6_wr_idx] <= pop_item.src_high;
            v6_net_lo_reg[v6_wr_idx] <= pop_item.src_low;
            v6_prefix_reg[v6_wr_idx] <= pop_item.entry_prefix;
        end
        if (load)
        begin
            out_data_reg.pad        <= '0;
            out_data_reg.direction  <= pop_item.direction;
            out_data_reg.owner_id   <= pop_item.owner_id;
            out_data_reg.byte_count <= pop_item.byte_count;
            out_data_reg.src_high   <= pop_item.src_high;
            out_data_reg.src_low    <= pop_item.src_low;
            out_data_reg.dst_high   <= pop_item.dst_high;
            out_data_reg.dst_low    <= pop_item.dst_low;
            out_v6_reg              <= (pop_item.kind == KIND_PKT_V6);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_data_reg);
    assign m_tuser  = out_v6_reg;

    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && ((pop_item.kind == KIND_WR_V4) || (pop_item.kind == KIND_WR_V6)))
        |=> !$rose(out_valid_reg))
        else $error("table write produced a result");

    a_drop_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && drop && !out_valid_reg) |=> !out_valid_reg)
        else $error("dropped packet produced a result");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!out_valid_reg || m_tready))
        else $error("output register overwritten while held");

endmodule

// ===== rtl/core/ip_prefix_event_filter.sv =====
// Top level of the IP prefix event filter: APB config registers, front end,
// work queue and back end. Depends on ipef_pkg, ipef_front, ipef_queue, ipef_back.
`timescale 1ns / 1ps

// The filter takes one request per cycle on the slave stream while the queue
// has room: a packet event (tuser = 0) or a write of one IPv4 net/mask entry
// (tuser = 1) or one IPv6 net/prefix entry (tuser = 2). Packets whose IP
// version is neither 4 nor 6, and requests with tuser = 3, are consumed
// without effect. The front end classifies each request and places it in a
// two-entry queue; the back end pops one request per cycle unless its
// output register is held, compares both addresses against every table
// entry below the matching count register in parallel (one compare lane per
// entry), and either drops the event or loads it into the output register.
// Sustained rate is one request per cycle while m_tready stays high; a
// surviving packet passes a queue slot, then the compare and output
// register. Table writes stay in order with packets. IPv4 results carry
// zero in the high words and in bits 63..32 of the low words. Prefix
// lengths above 128 are stored as 128. Table entries are not cleared at
// reset: set the count registers only after writing the entries below them.
// Write config registers only while the filter is idle.
// Registers: 0x0 ipv4_entry_count, 0x4 ipv6_entry_count, 0x8 drop_when_either
// (0 drops when both addresses match, 1 when either does).

module ip_prefix_event_filter
    import ipef_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // slave stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // direction[0], owner_id[32:1], byte_count[64:33], ip_version[68:65],
    // src_high[132:69], src_low[196:133], dst_high[260:197], dst_low[324:261],
    // entry_index[328:325], entry_mask[360:329], entry_prefix[368:361], zero pad
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // opcode[1:0]
    input  logic [1:0]             s_tuser,
    // master stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // out_direction[0], out_owner_id[32:1], out_byte_count[64:33],
    // out_src_high[128:65], out_src_low[192:129], out_dst_high[256:193],
    // out_dst_low[320:257], zero pad
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // is_v6[0]
    output logic                   m_tuser,
    // APB config port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    logic [CNT_REG_W-1:0] v4_count_reg;
    logic [CNT_REG_W-1:0] v6_count_reg;
    logic                 drop_mode_reg;
    filter_cfg_t          cfg;
    logic                 cfg_write;

    logic       push_valid, push_ready;
    work_item_t push_item;
    logic       pop_valid, pop_ready;
    work_item_t pop_item;

    // ------------------------------------------------------------------
    // Config registers; write lands on the access cycle
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_count_reg  <= '0;
            v6_count_reg  <= '0;
            drop_mode_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_IPV4_COUNT: v4_count_reg  <= pwdata[CNT_REG_W-1:0];
                REG_IPV6_COUNT: v6_count_reg  <= pwdata[CNT_REG_W-1:0];
                REG_DROP_MODE:  drop_mode_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_IPV4_COUNT: prdata = APB_DATA_W'(v4_count_reg);
            REG_IPV6_COUNT: prdata = APB_DATA_W'(v6_count_reg);
            REG_DROP_MODE:  prdata = APB_DATA_W'(drop_mode_reg);
            default:        prdata = '0;
        endcase
    end

    assign cfg.ipv4_entry_count = v4_count_reg;
    assign cfg.ipv6_entry_count = v6_count_reg;
    assign cfg.drop_when_either = drop_mode_reg;

    // ------------------------------------------------------------------
    // Front end, queue, back end
    // ------------------------------------------------------------------
    ipef_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    ipef_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    ipef_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
